// ----- sv/qte_pkg.sv -----
// Package for the quaternion to Euler angle converter.
// Holds payload structs, datapath widths, the CORDIC arctangent table and rounding.
// No dependencies.
`default_nettype none

package qte_pkg;

  // Default number of CORDIC micro-rotations.
  localparam int CORDIC_ITERATIONS = 16;

  // Datapath widths: atan2 arguments, CORDIC x/y, CORDIC angle.
  localparam int AW = 34;
  localparam int XW = 38;
  localparam int ZW = 34;

  // Square root: 62-bit radicand, one result bit per stage.
  localparam int RADW = 62;
  localparam int ROOTW = 31;
  localparam int SQ_STEPS = RADW / 2;
  localparam int REMW = 35;

  localparam logic [30:0] SING_LIMIT_RESET = 31'd1073740750;
  localparam logic signed [ZW-1:0] HALF_PI30 = ZW'(64'sd1686629713);
  localparam int ANG_MAX = 25736;

  // Register index of the configuration port.
  localparam logic REG_SINGULAR_LIMIT = 1'b0;

  // atan(2^-i) in units of 2^-30 rad.
  localparam logic [30:0] ATAN_TAB [24] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
    31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
    31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
    31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256, 31'd128
  };

  typedef struct packed {
    logic signed [15:0] q_scalar;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
    logic               singular;
  } euler_t;

  // atan2 arguments for roll and yaw.
  typedef struct packed {
    logic signed [AW-1:0] ry;
    logic signed [AW-1:0] rx;
    logic signed [AW-1:0] yy;
    logic signed [AW-1:0] yx;
  } args_t;

  // Round an angle in units of 2^-30 rad to Q3.13 and saturate.
  function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] z);
    logic signed [ZW:0] t;
    t = ((ZW+1)'(z) + (ZW+1)'(65536)) >>> 17;
    if (t > ANG_MAX) t = (ZW+1)'(ANG_MAX);
    if (t < -ANG_MAX) t = -(ZW+1)'(ANG_MAX);
    return t[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/quaternion_to_euler_angles.sv -----
// Quaternion to Euler angle converter: top level with pipeline, delay lines and register port.
// Depends on qte_pkg, qte_isqrt and qte_cordic.
//
//   channel   direction  handshake                 word
//   quat      in         quat_valid/quat_ready     qte_pkg::quat_t
//   euler     out        euler_valid/euler_ready   qte_pkg::euler_t
//   apb       in/out     psel/penable/pready       singular_limit at byte 0
//
// One word enters per cycle while the pipeline advances; it passes through the product,
// argument, square and radicand stages, the 31-stage square root, the CORDIC pipeline and the output register.
// The whole pipeline advances together; it holds while a result waits untaken.
// Synchronous reset clears the valid bits and restores singular_limit.
`default_nettype none

module quaternion_to_euler_angles #(
  parameter int CORDIC_ITERATIONS = qte_pkg::CORDIC_ITERATIONS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            quat_valid,
  output logic                 quat_ready,
  input  wire qte_pkg::quat_t  quat,
  output logic                 euler_valid,
  input  wire logic            euler_ready,
  output qte_pkg::euler_t      euler,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int AW = qte_pkg::AW;
  localparam int XW = qte_pkg::XW;
  localparam int ZW = qte_pkg::ZW;
  localparam int ARG_DLY = 2 + qte_pkg::SQ_STEPS;
  localparam int FLG_DLY = ARG_DLY + 1 + CORDIC_ITERATIONS;
  localparam int NV = ARG_DLY + CORDIC_ITERATIONS + 4;
  localparam logic signed [31:0] ONE30 = 32'sd1073741824;

  logic [30:0] singular_limit;
  logic        advance;
  logic [NV-1:0] vld;

  // Register port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == qte_pkg::REG_SINGULAR_LIMIT) ? {1'b0, singular_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      singular_limit <= qte_pkg::SING_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == qte_pkg::REG_SINGULAR_LIMIT) begin
      singular_limit <= pwdata[30:0];
    end
  end

  // Pipeline moves when the output register is empty or being taken.
  assign advance     = !vld[NV-1] || euler_ready;
  assign quat_ready  = advance;
  assign euler_valid = vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NV-2:0], quat_valid};
    end
  end

  // Stage a: all pairwise products.
  logic signed [31:0] p00, p11, p22, p33, p01, p23, p13, p02, p12, p03;

  always_ff @(posedge clk) begin
    if (advance) begin
      p00 <= quat.q_scalar * quat.q_scalar;
      p11 <= quat.q_x * quat.q_x;
      p22 <= quat.q_y * quat.q_y;
      p33 <= quat.q_z * quat.q_z;
      p01 <= quat.q_scalar * quat.q_x;
      p23 <= quat.q_y * quat.q_z;
      p13 <= quat.q_x * quat.q_z;
      p02 <= quat.q_scalar * quat.q_y;
      p12 <= quat.q_x * quat.q_y;
      p03 <= quat.q_scalar * quat.q_z;
    end
  end

  // Stage b: s, singular decision, clamp and atan2 arguments.
  logic signed [35:0] s_c;
  logic        [35:0] sabs_c;
  logic signed [31:0] sc_c;
  logic               sing_c;
  qte_pkg::args_t     args_c;

  always_comb begin
    s_c    = (36'(p23) + 36'(p01)) <<< 3;
    sabs_c = s_c[35] ? 36'(-s_c) : 36'(s_c);
    sing_c = sabs_c > 36'(singular_limit);
    if (s_c > 36'(ONE30)) sc_c = ONE30;
    else if (s_c < -36'(ONE30)) sc_c = -ONE30;
    else sc_c = s_c[31:0];
    if (sing_c) begin
      args_c.ry = (AW'(p13) + AW'(p02)) <<< 1;
      args_c.rx = AW'(p00) + AW'(p11) - AW'(p22) - AW'(p33);
    end else begin
      args_c.ry = (AW'(p13) - AW'(p02)) <<< 1;
      args_c.rx = AW'(p00) - AW'(p11) - AW'(p22) + AW'(p33);
    end
    args_c.yy = (AW'(p12) - AW'(p03)) <<< 1;
    args_c.yx = AW'(p00) - AW'(p11) + AW'(p22) - AW'(p33);
  end

  logic signed [31:0] sc_b;
  logic [30:0]        scm_b;
  logic               sing_b;
  qte_pkg::args_t     args_b;

  always_ff @(posedge clk) begin
    if (advance) begin
      sc_b   <= sc_c;
      scm_b  <= sc_c[31] ? 31'(-sc_c) : sc_c[30:0];
      sing_b <= sing_c;
      args_b <= args_c;
    end
  end

  // Stage c: square of the clamped s. Stage d: radicand 1 - s^2.
  logic signed [31:0]            sc_cc, sc_d;
  logic [61:0]                   sq_c;
  logic [qte_pkg::RADW-1:0]      rad_d;

  always_ff @(posedge clk) begin
    if (advance) begin
      sq_c  <= scm_b * scm_b;
      sc_cc <= sc_b;
      rad_d <= (qte_pkg::RADW'(1) << 60) - qte_pkg::RADW'(sq_c);
      sc_d  <= sc_cc;
    end
  end

  logic [qte_pkg::ROOTW-1:0] root;

  qte_isqrt u_isqrt (
    .clk     (clk),
    .advance (advance),
    .rad     (rad_d),
    .root    (root)
  );

  // Clamped s rides along with the square root stages.
  logic signed [31:0] sc_dly [qte_pkg::SQ_STEPS];

  always_ff @(posedge clk) begin
    if (advance) begin
      sc_dly[0] <= sc_d;
      for (int j = 1; j < qte_pkg::SQ_STEPS; j++) sc_dly[j] <= sc_dly[j-1];
    end
  end

  // Roll and yaw arguments wait until the pitch arguments are ready.
  qte_pkg::args_t arg_dly [ARG_DLY];
  logic           flg_dly [FLG_DLY];

  always_ff @(posedge clk) begin
    if (advance) begin
      arg_dly[0] <= args_b;
      for (int j = 1; j < ARG_DLY; j++) arg_dly[j] <= arg_dly[j-1];
      flg_dly[0] <= sing_b;
      for (int j = 1; j < FLG_DLY; j++) flg_dly[j] <= flg_dly[j-1];
    end
  end

  logic signed [ZW-1:0] pz, rz, yz;

  qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_pitch (
    .clk     (clk),
    .advance (advance),
    .vec_y   (XW'(sc_dly[qte_pkg::SQ_STEPS-1])),
    .vec_x   ($signed(XW'(root))),
    .angle   (pz)
  );

  qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_roll (
    .clk     (clk),
    .advance (advance),
    .vec_y   (XW'(arg_dly[ARG_DLY-1].ry)),
    .vec_x   (XW'(arg_dly[ARG_DLY-1].rx)),
    .angle   (rz)
  );

  qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_yaw (
    .clk     (clk),
    .advance (advance),
    .vec_y   (XW'(arg_dly[ARG_DLY-1].yy)),
    .vec_x   (XW'(arg_dly[ARG_DLY-1].yx)),
    .angle   (yz)
  );

  // Output register: rounding, sign of roll and yaw, singular branch.
  logic sing_o;
  assign sing_o = flg_dly[FLG_DLY-1];

  always_ff @(posedge clk) begin
    if (advance) begin
      euler.pitch    <= qte_pkg::to_q13(pz);
      euler.roll     <= qte_pkg::to_q13(sing_o ? rz : -rz);
      euler.yaw      <= sing_o ? 16'sd0 : qte_pkg::to_q13(-yz);
      euler.singular <= sing_o;
    end
  end

  // Checks.
  a_rst_clears: assert property (@(posedge clk) rst |=> !euler_valid)
    else $error("output valid after reset");

  a_yaw_zero: assert property (@(posedge clk) disable iff (rst)
    euler_valid && euler.singular |-> euler.yaw == 16'sd0)
    else $error("yaw not zero in singular case");

  a_range: assert property (@(posedge clk) disable iff (rst)
    euler_valid |-> (euler.pitch <= 16'sd25736 && euler.pitch >= -16'sd25736 &&
                     euler.roll <= 16'sd25736 && euler.roll >= -16'sd25736))
    else $error("angle out of range");

endmodule

`default_nettype wire

// ----- sv/qte_isqrt.sv -----
// Pipelined floor square root, one result bit per register stage.
// Depends on qte_pkg for widths.
`default_nettype none

module qte_isqrt (
  input  wire logic                      clk,
  input  wire logic                      advance,
  input  wire logic [qte_pkg::RADW-1:0]  rad,
  output logic      [qte_pkg::ROOTW-1:0] root
);

  localparam int N = qte_pkg::SQ_STEPS;

  logic [qte_pkg::REMW-1:0]  rem  [N];
  logic [qte_pkg::ROOTW-1:0] rt   [N];
  logic [qte_pkg::RADW-1:0]  vsh  [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [qte_pkg::REMW-1:0]  rem_prev;
    logic [qte_pkg::ROOTW-1:0] rt_prev;
    logic [qte_pkg::RADW-1:0]  v_prev;
    logic [qte_pkg::REMW-1:0]  r2;
    logic [qte_pkg::REMW-1:0]  trial;
    logic                      ge;

    if (k == 0) begin : g_first
      assign rem_prev = '0;
      assign rt_prev  = '0;
      assign v_prev   = rad;
    end else begin : g_next
      assign rem_prev = rem[k-1];
      assign rt_prev  = rt[k-1];
      assign v_prev   = vsh[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
      r2    = {rem_prev[qte_pkg::REMW-3:0], v_prev[qte_pkg::RADW-1 -: 2]};
      trial = qte_pkg::REMW'({rt_prev, 2'b01});
      ge    = (r2 >= trial);
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem[k] <= ge ? (r2 - trial) : r2;
        rt[k]  <= {rt_prev[qte_pkg::ROOTW-2:0], ge};
        vsh[k] <= {v_prev[qte_pkg::RADW-3:0], 2'b00};
      end
    end
  end

  assign root = rt[N-1];

endmodule

`default_nettype wire

// ----- sv/qte_cordic.sv -----
// Pipelined vectoring CORDIC giving atan2(y, x), one micro-rotation per stage.
// Depends on qte_pkg for widths and the arctangent table.
`default_nettype none

module qte_cordic #(
  parameter int ITER = qte_pkg::CORDIC_ITERATIONS
) (
  input  wire logic                          clk,
  input  wire logic                          advance,
  input  wire logic signed [qte_pkg::XW-1:0] vec_y,
  input  wire logic signed [qte_pkg::XW-1:0] vec_x,
  output logic signed      [qte_pkg::ZW-1:0] angle
);

  logic signed [qte_pkg::XW-1:0] cx   [ITER+1];
  logic signed [qte_pkg::XW-1:0] cy   [ITER+1];
  logic signed [qte_pkg::ZW-1:0] cz   [ITER+1];
  logic                          cnul [ITER+1];

  // Pre-rotation by a quarter turn brings x into the right half plane.
  always_ff @(posedge clk) begin
    if (advance) begin
      cnul[0] <= (vec_x == '0) && (vec_y == '0);
      if (vec_x < 0) begin
        if (vec_y >= 0) begin
          cx[0] <= vec_y;
          cy[0] <= -vec_x;
          cz[0] <= qte_pkg::HALF_PI30;
        end else begin
          cx[0] <= -vec_y;
          cy[0] <= vec_x;
          cz[0] <= -qte_pkg::HALF_PI30;
        end
      end else begin
        cx[0] <= vec_x;
        cy[0] <= vec_y;
        cz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_rot
    localparam logic signed [qte_pkg::ZW-1:0] ANG = qte_pkg::ZW'(qte_pkg::ATAN_TAB[i]);

    // Rotate toward the x axis by atan(2^-i).
    always_ff @(posedge clk) begin
      if (advance) begin
        cnul[i+1] <= cnul[i];
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ANG;
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ANG;
        end
      end
    end
  end

  // Both arguments zero give a zero angle.
  assign angle = cnul[ITER] ? '0 : cz[ITER];

endmodule

`default_nettype wire
